### rtl/core/wcw_pkg.sv
`default_nettype none

package wcw_pkg;

  // Parser phases of the chunk walk.
  typedef enum logic [2:0] {
    MODE_ID   = 3'd0,
    MODE_SIZE = 3'd1,
    MODE_SKIP = 3'd2,
    MODE_DATA = 3'd3,
    MODE_BAD  = 3'd4
  } wcw_mode_t;

  // Result kinds as they leave the block.
  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_END       = 2'd1,
    KIND_BAD_WIDTH = 2'd2
  } wcw_kind_t;

  localparam logic [31:0] DATA_TAG     = 32'h6461_7461;
  localparam logic [5:0]  CHUNKS_FROM  = 6'd12;
  localparam logic [5:0]  OFF_CHANNELS = 6'd22;
  localparam logic [5:0]  OFF_RATE     = 6'd24;
  localparam logic [5:0]  OFF_BITS     = 6'd34;
  localparam logic [5:0]  OFF_LIMIT    = 6'd36;

  // One classified word handed from the parser to the formatter.
  typedef struct packed {
    wcw_kind_t   kind;
    logic [31:0] raw;
    logic [7:0]  channel_count;
    logic [12:0] sample_width;
    logic [31:0] rate_hz;
    logic        end_flag;
  } wcw_cmd_t;

  // Queue status seen by the parser and the formatter.
  typedef struct packed {
    logic full;
    logic empty;
  } wcw_q_status_t;

endpackage

`default_nettype wire

### rtl/core/wcw_in_if.sv
`default_nettype none

interface wcw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       final_byte;

  modport source (output valid, output byte_value, output final_byte, input ready);
  modport sink (input valid, input byte_value, input final_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/wcw_out_if.sv
`default_nettype none

interface wcw_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] sample_value;
  logic               is_float;
  logic [7:0]         channel_count;
  logic [12:0]        sample_width;
  logic [31:0]        rate_hz;
  logic               end_flag;

  modport source (output valid, output kind, output sample_value, output is_float,
                  output channel_count, output sample_width, output rate_hz,
                  output end_flag, input ready);
  modport sink (input valid, input kind, input sample_value, input is_float,
                input channel_count, input sample_width, input rate_hz,
                input end_flag, output ready);
endinterface

`default_nettype wire

### rtl/core/wcw_front.sv
`default_nettype none

module wcw_front
  import wcw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  wcw_in_if.sink        in_ch,
  input  wcw_q_status_t q_status,
  output logic          push,
  output wcw_cmd_t      cmd
);

  wcw_mode_t   mode_r, mode_nxt;
  logic [5:0]  off_r, off_nxt;
  logic [31:0] id_shift_r, id_shift_nxt;
  logic [1:0]  fc_r, fc_nxt;
  logic [31:0] chunk_len_r, chunk_len_nxt;
  logic [31:0] skip_left_r, skip_left_nxt;
  logic [23:0] sample_bytes_r, sample_bytes_nxt;
  logic [7:0]  channels_r, channels_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] rate_r, rate_nxt;

  logic accept;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_ID;
      off_r          <= '0;
      id_shift_r     <= '0;
      fc_r           <= '0;
      chunk_len_r    <= '0;
      skip_left_r    <= '0;
      sample_bytes_r <= '0;
      channels_r     <= '0;
      bits_r         <= '0;
      rate_r         <= '0;
    end else begin
      mode_r         <= mode_nxt;
      off_r          <= off_nxt;
      id_shift_r     <= id_shift_nxt;
      fc_r           <= fc_nxt;
      chunk_len_r    <= chunk_len_nxt;
      skip_left_r    <= skip_left_nxt;
      sample_bytes_r <= sample_bytes_nxt;
      channels_r     <= channels_nxt;
      bits_r         <= bits_nxt;
      rate_r         <= rate_nxt;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [12:0] width_now;
    logic [31:0] len_full;
    logic [31:0] full;
    logic        emit;
    wcw_kind_t   kind;

    b    = in_ch.byte_value;
    emit = 1'b0;
    kind = KIND_END;

    mode_nxt         = mode_r;
    off_nxt          = off_r;
    id_shift_nxt     = id_shift_r;
    fc_nxt           = fc_r;
    chunk_len_nxt    = chunk_len_r;
    skip_left_nxt    = skip_left_r;
    sample_bytes_nxt = sample_bytes_r;
    channels_nxt     = channels_r;
    bits_nxt         = bits_r;
    rate_nxt         = rate_r;

    // Header capture stops once the data or bad phase is entered.
    if (mode_r != MODE_DATA && mode_r != MODE_BAD) begin
      if (off_r == OFF_CHANNELS) begin
        channels_nxt = b;
      end else if (off_r >= OFF_RATE && off_r < OFF_RATE + 6'd4) begin
        rate_nxt[{off_r[1:0], 3'b000} +: 8] = b;
      end else if (off_r == OFF_BITS) begin
        bits_nxt[7:0] = b;
      end else if (off_r == OFF_BITS + 6'd1) begin
        bits_nxt[15:8] = b;
      end
    end
    if (off_r < OFF_LIMIT) begin
      off_nxt = off_r + 6'd1;
    end
    width_now = bits_nxt[15:3];

    len_full = chunk_len_r;
    len_full[{fc_r, 3'b000} +: 8] = b;
    full = {8'h00, sample_bytes_r};
    full[{fc_r, 3'b000} +: 8] = b;

    unique case (mode_r)
      MODE_ID: begin
        if (off_r >= CHUNKS_FROM) begin
          id_shift_nxt = {id_shift_r[23:0], b};
          if (fc_r == 2'd3) begin
            fc_nxt        = '0;
            chunk_len_nxt = '0;
            mode_nxt      = MODE_SIZE;
          end else begin
            fc_nxt = fc_r + 2'd1;
          end
        end
      end
      MODE_SIZE: begin
        chunk_len_nxt = len_full;
        if (fc_r == 2'd3) begin
          fc_nxt = '0;
          if (id_shift_r == DATA_TAG) begin
            sample_bytes_nxt = '0;
            if (width_now >= 13'd1 && width_now <= 13'd4) begin
              mode_nxt = MODE_DATA;
            end else begin
              mode_nxt = MODE_BAD;
              emit     = 1'b1;
              kind     = KIND_BAD_WIDTH;
            end
          end else if (len_full == '0) begin
            mode_nxt = MODE_ID;
          end else begin
            skip_left_nxt = len_full;
            mode_nxt      = MODE_SKIP;
          end
        end else begin
          fc_nxt = fc_r + 2'd1;
        end
      end
      MODE_SKIP: begin
        skip_left_nxt = skip_left_r - 32'd1;
        if (skip_left_r == 32'd1) begin
          mode_nxt = MODE_ID;
        end
      end
      MODE_DATA: begin
        if (13'(fc_r) + 13'd1 >= width_now) begin
          emit             = 1'b1;
          kind             = KIND_SAMPLE;
          sample_bytes_nxt = '0;
          fc_nxt           = '0;
        end else begin
          sample_bytes_nxt = full[23:0];
          fc_nxt           = fc_r + 2'd1;
        end
      end
      MODE_BAD: begin
      end
      default: begin
      end
    endcase

    push               = accept && (emit || in_ch.final_byte);
    cmd.kind           = kind;
    cmd.raw            = (kind == KIND_SAMPLE) ? full : '0;
    cmd.channel_count  = channels_nxt;
    cmd.sample_width   = width_now;
    cmd.rate_hz        = rate_nxt;
    cmd.end_flag       = in_ch.final_byte;

    if (!accept) begin
      mode_nxt         = mode_r;
      off_nxt          = off_r;
      id_shift_nxt     = id_shift_r;
      fc_nxt           = fc_r;
      chunk_len_nxt    = chunk_len_r;
      skip_left_nxt    = skip_left_r;
      sample_bytes_nxt = sample_bytes_r;
      channels_nxt     = channels_r;
      bits_nxt         = bits_r;
      rate_nxt         = rate_r;
    end else if (in_ch.final_byte) begin
      // The last byte of a file leaves the parser ready for the next one.
      mode_nxt         = MODE_ID;
      off_nxt          = '0;
      id_shift_nxt     = '0;
      fc_nxt           = '0;
      chunk_len_nxt    = '0;
      skip_left_nxt    = '0;
      sample_bytes_nxt = '0;
      channels_nxt     = '0;
      bits_nxt         = '0;
      rate_nxt         = '0;
    end
  end

  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.final_byte |=> mode_r == MODE_ID && off_r == '0 && fc_r == '0)
    else $error("parser state not cleared after final byte");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_SKIP |-> skip_left_r != '0)
    else $error("skip phase entered with nothing to skip");

endmodule

`default_nettype wire

### rtl/core/wcw_fifo.sv
`default_nettype none

module wcw_fifo
  import wcw_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wcw_cmd_t      wr_data,
  input  wire logic     pop,
  output wcw_cmd_t      rd_data,
  output wcw_q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wcw_cmd_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign rd_data      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && status.full |-> pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

### rtl/core/wcw_back.sv
`default_nettype none

module wcw_back
  import wcw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wcw_cmd_t      q_data,
  input  wcw_q_status_t q_status,
  output logic          pop,
  wcw_out_if.source     out_ch
);

  logic               valid_r;
  logic [1:0]         kind_r;
  logic signed [31:0] value_r;
  logic               float_r;
  logic [7:0]         channels_r;
  logic [12:0]        width_r;
  logic [31:0]        rate_r;
  logic               end_r;

  logic [31:0] value_nxt;
  logic        float_nxt;

  assign pop = !q_status.empty && (!valid_r || out_ch.ready);

  // Sample conversion to Q1.31; four-byte samples pass as float bits.
  always_comb begin
    value_nxt = '0;
    float_nxt = 1'b0;
    if (q_data.kind == KIND_SAMPLE) begin
      case (q_data.sample_width[2:0])
        3'd1:    value_nxt = {~q_data.raw[7], q_data.raw[6:0], 24'h000000};
        3'd2:    value_nxt = {q_data.raw[15:0], 16'h0000};
        3'd3:    value_nxt = {q_data.raw[23:0], 8'h00};
        default: begin
          value_nxt = q_data.raw;
          float_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r     <= q_data.kind;
      value_r    <= value_nxt;
      float_r    <= float_nxt;
      channels_r <= q_data.channel_count;
      width_r    <= q_data.sample_width;
      rate_r     <= q_data.rate_hz;
      end_r      <= q_data.end_flag;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.sample_value  = value_r;
  assign out_ch.is_float      = float_r;
  assign out_ch.channel_count = channels_r;
  assign out_ch.sample_width  = width_r;
  assign out_ch.rate_hz       = rate_r;
  assign out_ch.end_flag      = end_r;

  a_nonsample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r != KIND_SAMPLE |-> value_r == '0 && !float_r)
    else $error("non-sample result carries sample bits");

endmodule

`default_nettype wire

### rtl/core/wav_chunk_walk_sample_decoder.sv
// Path: an input byte that completes a result word has that word written into the
// queue, and the word then moves from the queue into the output register.
// Throughput: one byte per cycle while the queue is not full.
// The output register and a QUEUE_DEPTH-word queue let input continue under stall.
// Reset is synchronous and active low; it clears the parser, queue and output
// valid. The final byte of each file also returns the parser to its reset state.
`default_nettype none

module wav_chunk_walk_sample_decoder
  import wcw_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  wcw_in_if.sink    in_ch,
  wcw_out_if.source out_ch
);

  // The front parser walks the RIFF structure one byte at a time. It captures
  // the channel count, sample rate and bits-per-sample fields from their fixed
  // header offsets, reads chunk identifiers and sizes, skips chunks that are
  // not "data", and assembles sample bytes. Each byte that completes a sample,
  // hits an unsupported width, or ends the file produces one word for the queue.
  wcw_cmd_t      push_cmd;
  wcw_cmd_t      pop_cmd;
  logic          push;
  logic          pop;
  wcw_q_status_t q_status;

  wcw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .cmd      (push_cmd)
  );

  // The queue decouples the parser from the result side, so the parser keeps
  // taking bytes while the consumer holds off, until the queue is full.
  wcw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_cmd),
    .pop     (pop),
    .rd_data (pop_cmd),
    .status  (q_status)
  );

  // The back end turns raw sample bytes into Q1.31 values (or float bits for
  // four-byte samples) and holds each result word in the output register.
  wcw_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (pop_cmd),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
